// File: src/lzc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lzc_pkg
// Shared types, constants and zigzag helpers for the Lorenzo residual codec.
// ----------------------------------------------------------------------------
package lzc_pkg;

  localparam int unsigned WORD_W          = 64;
  localparam int unsigned CFG_DATA_W      = 13;
  localparam int unsigned CFG_INDEX_W     = 1;
  localparam int unsigned MODE_W          = 2;
  localparam int unsigned DEF_MAX_ROW_WIDTH = 4096;

  // register indexes of the configuration port
  localparam logic [CFG_INDEX_W-1:0] REG_ROW_WIDTH  = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_CODEC_MODE = 1'd1;

  localparam logic [CFG_DATA_W-1:0] ROW_WIDTH_RESET = 13'd4096;

  // codec modes; the unused code behaves as pass-through
  localparam logic [MODE_W-1:0] MODE_ENCODE = 2'd0;
  localparam logic [MODE_W-1:0] MODE_DECODE = 2'd1;
  localparam logic [MODE_W-1:0] MODE_PASS   = 2'd2;

  // neighbor availability of one item
  typedef struct packed {
    logic has_left;
    logic has_up;
  } nbr_flags_t;

  localparam int unsigned FLAGS_W = $bits(nbr_flags_t);

  function automatic logic [WORD_W-1:0] zz_encode(input logic [WORD_W-1:0] d);
    zz_encode = {d[WORD_W-2:0], 1'b0} ^ {WORD_W{d[WORD_W-1]}};
  endfunction

  function automatic logic [WORD_W-1:0] zz_decode(input logic [WORD_W-1:0] z);
    zz_decode = {1'b0, z[WORD_W-1:1]} ^ {WORD_W{z[0]}};
  endfunction

endpackage : lzc_pkg
`default_nettype wire

// File: src/lzc_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lzc_front
// Accepts input words, tracks the position in the frame and tags each word
// with its column and which neighbors exist.
// ----------------------------------------------------------------------------
module lzc_front
  import lzc_pkg::*;
#(
  parameter int unsigned MAX_ROW_WIDTH = DEF_MAX_ROW_WIDTH,
  localparam int unsigned IDX_W = (MAX_ROW_WIDTH > 1) ? $clog2(MAX_ROW_WIDTH) : 1
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  data_valid,
  input  wire logic                  frame_last,
  input  wire logic [CFG_DATA_W-1:0] row_width,
  input  wire logic                  q_full,
  output logic                       data_ready,
  output logic                       push,
  output logic [IDX_W-1:0]           push_x,
  output nbr_flags_t                 push_flags
);

  logic [IDX_W-1:0] column_index;
  logic [IDX_W-1:0] column_index_next;
  logic             past_first_row;
  logic             past_first_row_next;
  logic [31:0]      width_raw;
  logic [31:0]      width_eff;
  logic [31:0]      x_inc;

  assign data_ready = !q_full;
  assign push       = data_valid && data_ready;

  // classify the current item
  assign push_x              = column_index;
  assign push_flags.has_left = (column_index != '0);
  assign push_flags.has_up   = past_first_row;

  // effective row width: zero acts as one, oversize clamps to the maximum
  always_comb begin
    width_raw = 32'(row_width);
    if (width_raw == 32'd0) begin
      width_eff = 32'd1;
    end else if (width_raw > 32'(MAX_ROW_WIDTH)) begin
      width_eff = 32'(MAX_ROW_WIDTH);
    end else begin
      width_eff = width_raw;
    end
  end

  // next position after this item
  always_comb begin
    x_inc               = 32'(column_index) + 32'd1;
    column_index_next   = column_index;
    past_first_row_next = past_first_row;
    if (x_inc >= width_eff) begin
      column_index_next   = '0;
      past_first_row_next = 1'b1;
    end else begin
      column_index_next = x_inc[IDX_W-1:0];
    end
    if (frame_last) begin
      column_index_next   = '0;
      past_first_row_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_index   <= '0;
      past_first_row <= 1'b0;
    end else if (push) begin
      column_index   <= column_index_next;
      past_first_row <= past_first_row_next;
    end
  end

endmodule : lzc_front
`default_nettype wire

// File: src/lzc_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lzc_queue
// Two-entry queue between the front and the back, full rate with a
// simultaneous push and pop.
// ----------------------------------------------------------------------------
module lzc_queue
  import lzc_pkg::*;
#(
  parameter int unsigned DW = 8
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  input  wire logic [DW-1:0] push_data,
  input  wire logic          pop,
  output logic               q_valid,
  output logic               q_full,
  output logic [DW-1:0]      q_data
);

  logic [DW-1:0] slot [2];
  logic          wr_ptr;
  logic          rd_ptr;
  logic [1:0]    count;

  assign q_valid = (count != 2'd0);
  assign q_full  = (count == 2'd2);
  assign q_data  = slot[rd_ptr];

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) slot[wr_ptr] <= push_data;
  end

endmodule : lzc_queue
`default_nettype wire

// File: src/lzc_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lzc_back
// Reads the line store, forms the prediction, encodes or rebuilds the word
// and holds the result in the output register.
// ----------------------------------------------------------------------------
module lzc_back
  import lzc_pkg::*;
#(
  parameter int unsigned MAX_ROW_WIDTH = DEF_MAX_ROW_WIDTH,
  localparam int unsigned IDX_W = (MAX_ROW_WIDTH > 1) ? $clog2(MAX_ROW_WIDTH) : 1
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic [MODE_W-1:0] codec_mode,
  input  wire logic              q_valid,
  input  wire logic [WORD_W-1:0] q_word,
  input  wire logic [IDX_W-1:0]  q_x,
  input  nbr_flags_t             q_flags,
  output logic                   pop,
  input  wire logic              result_ready,
  output logic                   result_valid,
  output logic [WORD_W-1:0]      result_word
);

  logic [WORD_W-1:0] row_store [MAX_ROW_WIDTH];
  logic [WORD_W-1:0] rd_word;

  // read stage registers
  logic              a_valid;
  logic [WORD_W-1:0] a_word;
  logic [IDX_W-1:0]  a_x;
  nbr_flags_t        a_flags;
  logic              a_fwd;
  logic [WORD_W-1:0] a_fwd_word;
  logic              a_ready;
  logic              a_adv;

  logic [WORD_W-1:0] left_value;
  logic [WORD_W-1:0] upleft_value;
  logic [WORD_W-1:0] up;
  logic [WORD_W-1:0] pred;
  logic [WORD_W-1:0] value;
  logic [WORD_W-1:0] result;

  assign a_adv   = a_valid && (!result_valid || result_ready);
  assign a_ready = !a_valid || a_adv;
  assign pop     = q_valid && a_ready;

  // line store: one read on pop, one write as an item completes
  always_ff @(posedge clk) begin
    if (pop)   rd_word <= row_store[q_x];
    if (a_adv) row_store[a_x] <= value;
  end

  // read stage; a write to the same column on the same edge is forwarded
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (a_ready) begin
      a_valid <= q_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      a_word     <= q_word;
      a_x        <= q_x;
      a_flags    <= q_flags;
      a_fwd      <= a_adv && (q_x == a_x);
      a_fwd_word <= value;
    end
  end

  // prediction from the neighbors
  always_comb begin
    up = a_fwd ? a_fwd_word : rd_word;
    if (a_flags.has_left && a_flags.has_up) begin
      pred = left_value + up - upleft_value;
    end else if (a_flags.has_up) begin
      pred = up;
    end else if (a_flags.has_left) begin
      pred = left_value;
    end else begin
      pred = '0;
    end
  end

  // mode select
  always_comb begin
    case (codec_mode)
      MODE_ENCODE: begin
        value  = a_word;
        result = zz_encode(a_word - pred);
      end
      MODE_DECODE: begin
        value  = zz_decode(a_word) + pred;
        result = value;
      end
      default: begin
        value  = a_word;
        result = a_word;
      end
    endcase
  end

  // neighbor registers follow the completed item
  always_ff @(posedge clk) begin
    if (rst) begin
      left_value   <= '0;
      upleft_value <= '0;
    end else if (a_adv) begin
      left_value   <= value;
      upleft_value <= up;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (a_adv) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (a_adv) result_word <= result;
  end

endmodule : lzc_back
`default_nettype wire

// File: src/lorenzo_zigzag_residual_codec.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lorenzo_zigzag_residual_codec
// Two-dimensional Lorenzo predictor with zigzag residuals on 64-bit words.
// ----------------------------------------------------------------------------
// Takes one word per cycle and gives one result word per cycle when the
// output side keeps up; a word passes through the queue, then the read
// stage that reads the line store, and then sits in the output register.
// The rate is set by the line store, which takes one read and one write
// per word; a row of one value is served by forwarding the word just
// written. The line store has no clearing pass: columns not yet written
// in a frame's first row are never used.
// Configuration is taken at any time with cfg_ready held high, and must be
// written only while no word is in flight.
module lorenzo_zigzag_residual_codec
  import lzc_pkg::*;
#(
  parameter int unsigned MAX_ROW_WIDTH = DEF_MAX_ROW_WIDTH,
  localparam int unsigned IDX_W = (MAX_ROW_WIDTH > 1) ? $clog2(MAX_ROW_WIDTH) : 1
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   data_valid,
  output logic                        data_ready,
  input  wire logic [WORD_W-1:0]      data_word,
  input  wire logic                   frame_last,
  output logic                        result_valid,
  input  wire logic                   result_ready,
  output logic [WORD_W-1:0]           result_word,
  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam int unsigned Q_W = WORD_W + IDX_W + FLAGS_W;

  logic [CFG_DATA_W-1:0] row_width;
  logic [MODE_W-1:0]     codec_mode;

  logic             q_full;
  logic             q_valid;
  logic             q_push;
  logic             q_pop;
  logic [IDX_W-1:0] push_x;
  nbr_flags_t       push_flags;
  logic [Q_W-1:0]   q_data;
  logic [WORD_W-1:0] q_word;
  logic [IDX_W-1:0] q_x;
  nbr_flags_t       q_flags;

  // configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_width  <= ROW_WIDTH_RESET;
      codec_mode <= MODE_ENCODE;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_ROW_WIDTH:  row_width  <= cfg_data;
        REG_CODEC_MODE: codec_mode <= cfg_data[MODE_W-1:0];
        default: ;
      endcase
    end
  end

  lzc_front #(
    .MAX_ROW_WIDTH(MAX_ROW_WIDTH)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .data_valid (data_valid),
    .frame_last (frame_last),
    .row_width  (row_width),
    .q_full     (q_full),
    .data_ready (data_ready),
    .push       (q_push),
    .push_x     (push_x),
    .push_flags (push_flags)
  );

  lzc_queue #(
    .DW(Q_W)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data ({data_word, push_x, push_flags}),
    .pop       (q_pop),
    .q_valid   (q_valid),
    .q_full    (q_full),
    .q_data    (q_data)
  );

  assign q_word  = q_data[Q_W-1 -: WORD_W];
  assign q_x     = q_data[FLAGS_W +: IDX_W];
  assign q_flags = nbr_flags_t'(q_data[FLAGS_W-1:0]);

  lzc_back #(
    .MAX_ROW_WIDTH(MAX_ROW_WIDTH)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .codec_mode   (codec_mode),
    .q_valid      (q_valid),
    .q_word       (q_word),
    .q_x          (q_x),
    .q_flags      (q_flags),
    .pop          (q_pop),
    .result_ready (result_ready),
    .result_valid (result_valid),
    .result_word  (result_word)
  );

  // the back never takes from an empty queue
  assert property (@(posedge clk) disable iff (rst) q_pop |-> q_valid)
    else $error("pop from empty queue");

  // a stalled input means the queue holds work to drain
  assert property (@(posedge clk) disable iff (rst) !data_ready |-> q_valid)
    else $error("input stalled with empty queue");

  // the word after a frame end sits at the origin
  assert property (@(posedge clk) disable iff (rst)
    q_push && frame_last |=> !q_push || (!push_flags.has_left && !push_flags.has_up))
    else $error("frame did not restart at origin");

endmodule : lorenzo_zigzag_residual_codec
`default_nettype wire
